/* rtl/bclp_pkg.sv */
`default_nettype none

package bclp_pkg;

    localparam int unsigned WINDOW_W  = 8;
    localparam int unsigned HOLD_W    = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET    = WINDOW_W'(50);
    localparam logic [HOLD_W-1:0]   LONG_PUSH_RESET = HOLD_W'(500);
    localparam logic [HOLD_W-1:0]   HOLD_MAX        = {HOLD_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK_WINDOW = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PUSH_TICKS     = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_PRESS  = 2'd1,
        PH_LONG   = 2'd2,
        PH_DOUBLE = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [HOLD_W-1:0]   hold_count;
        logic [WINDOW_W-1:0] window_count;
        logic                click_count;
        logic                window_active;
        logic                long_flag;
        logic                double_flag;
    } bclp_state_t;

    typedef struct packed {
        logic [WINDOW_W-1:0] double_click_window;
        logic [HOLD_W-1:0]   long_push_ticks;
    } bclp_cfg_t;

    typedef struct packed {
        logic   long_push_flag;
        logic   double_click_flag;
        logic   restart_request;
        phase_t button_phase;
    } bclp_result_t;

endpackage

`default_nettype wire

/* rtl/bclp_step.sv */
`default_nettype none

// Next-state and result logic for one tick.
module bclp_step
    import bclp_pkg::*;
(
    input  bclp_state_t  state_cur,
    input  bclp_cfg_t    cfg,
    input  logic         pin_level,
    output bclp_state_t  state_nxt,
    output bclp_result_t result
);

    logic        pressed;
    logic        restart;
    bclp_state_t aged;

    assign pressed = ~pin_level;

    // The open click window ages before the phase logic looks at it.
    always_comb
    begin
        aged = state_cur;
        if (state_cur.window_active)
        begin
            aged.window_count = state_cur.window_count + WINDOW_W'(1);
            if (state_cur.window_count > cfg.double_click_window)
            begin
                aged.click_count   = 1'b0;
                aged.window_count  = '0;
                aged.window_active = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_nxt = aged;
        restart   = 1'b0;
        unique case (state_cur.phase)
            PH_IDLE:
            begin
                state_nxt.long_flag   = 1'b0;
                state_nxt.double_flag = 1'b0;
                if (pressed)
                begin
                    state_nxt.phase      = PH_PRESS;
                    state_nxt.hold_count = '0;
                end
            end
            PH_PRESS:
            begin
                if (state_cur.hold_count != HOLD_MAX)
                begin
                    state_nxt.hold_count = state_cur.hold_count + HOLD_W'(1);
                end
                if (!pressed)
                begin
                    if (aged.click_count)
                    begin
                        state_nxt.click_count   = 1'b0;
                        state_nxt.window_active = 1'b0;
                        state_nxt.window_count  = '0;
                        state_nxt.phase         = PH_DOUBLE;
                    end
                    else
                    begin
                        state_nxt.window_active = 1'b1;
                        state_nxt.click_count   = 1'b1;
                        state_nxt.phase         = PH_IDLE;
                    end
                end
                else if (state_nxt.hold_count > cfg.long_push_ticks)
                begin
                    state_nxt.phase = PH_LONG;
                    restart         = 1'b1;
                end
            end
            PH_LONG:
            begin
                state_nxt.long_flag = 1'b1;
                if (!pressed)
                begin
                    state_nxt.phase = PH_IDLE;
                end
            end
            PH_DOUBLE:
            begin
                state_nxt.double_flag = 1'b1;
                if (!pressed)
                begin
                    state_nxt.phase = PH_IDLE;
                end
            end
            default:
            begin
                state_nxt.phase = PH_IDLE;
            end
        endcase
    end

    assign result.long_push_flag    = state_nxt.long_flag;
    assign result.double_click_flag = state_nxt.double_flag;
    assign result.restart_request   = restart;
    assign result.button_phase      = state_nxt.phase;

endmodule

`default_nettype wire

/* rtl/bclp_cfg_regs.sv */
`default_nettype none

// Configuration register file; writes to unlisted indexes are dropped.
module bclp_cfg_regs
    import bclp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_DAT_W-1:0] wr_data,
    output bclp_cfg_t            cfg
);

    bclp_cfg_t cfg_reg;
    bclp_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_DOUBLE_CLICK_WINDOW:
                    cfg_next.double_click_window = wr_data[WINDOW_W-1:0];
                REG_LONG_PUSH_TICKS:
                    cfg_next.long_push_ticks = wr_data[HOLD_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.double_click_window <= WINDOW_RESET;
            cfg_reg.long_push_ticks     <= LONG_PUSH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/button_click_long_press_detector_core.sv */
`default_nettype none

// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    pin_level
// result    out        out_valid / out_ready  long_push_flag, double_click_flag,
//                                             restart_request, button_phase
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The result of an input beat appears in the output register on the cycle after
// acceptance, and a new beat is taken every cycle while the result side keeps
// up. The step logic between the state and output registers is combinational.
// Reset brings the phase to idle, clears all timers and loads the register
// defaults (window 50, long push 500). A stalled result holds the output
// register and blocks input only while it waits.
module button_click_long_press_detector_core
    import bclp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 pin_level,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 long_push_flag,
    output logic                 double_click_flag,
    output logic                 restart_request,
    output logic [1:0]           button_phase,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    bclp_cfg_t    cfg;
    bclp_state_t  state_reg;
    bclp_state_t  state_next;
    bclp_state_t  step_state;
    bclp_result_t step_result;
    bclp_result_t result_reg;
    bclp_result_t result_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         in_accept;

    // Configuration writes always taken; users must issue them only when idle.
    assign cfg_ready = 1'b1;

    bclp_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bclp_step u_step (
        .state_cur (state_reg),
        .cfg       (cfg),
        .pin_level (pin_level),
        .state_nxt (step_state),
        .result    (step_result)
    );

    // The output register frees up in the same cycle its beat is taken, so
    // input flows one beat per cycle while out_ready stays high.
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            state_next     = step_state;
            result_next    = step_result;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{phase: PH_IDLE, default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload register: loaded only on acceptance, no reset needed.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid         = out_valid_reg;
    assign long_push_flag    = result_reg.long_push_flag;
    assign double_click_flag = result_reg.double_click_flag;
    assign restart_request   = result_reg.restart_request;
    assign button_phase      = result_reg.button_phase;

endmodule

`default_nettype wire

/* rtl/bclp_checker.sv */
`default_nettype none

module bclp_checker
    import bclp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       long_push_flag,
    input logic       double_click_flag,
    input logic       restart_request,
    input logic [1:0] button_phase
);

    // A restart beat always enters the long-push phase before its flag is set.
    a_restart_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && restart_request) |->
            (button_phase == PH_LONG && !long_push_flag))
        else $error("restart request outside long-push entry");

    // The two phase flags never stand together; idle always clears both.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(long_push_flag && double_click_flag))
        else $error("long-push and double-click flags both set");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(long_push_flag) && $stable(double_click_flag)
             && $stable(restart_request) && $stable(button_phase)))
        else $error("result beat changed while stalled");

    // Input is only refused while a result waits to be taken.
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready) |-> (out_valid && !out_ready))
        else $error("input refused with a free output register");

endmodule

bind button_click_long_press_detector_core bclp_checker u_bclp_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .long_push_flag    (long_push_flag),
    .double_click_flag (double_click_flag),
    .restart_request   (restart_request),
    .button_phase      (button_phase)
);

`default_nettype wire

/* bench/tb_button_click_long_press_detector_core.sv */
module tb_button_click_long_press_detector_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bclp_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 4;

    localparam int TIMEOUT_NS = 2_000_000;

    // Two register indexes that the block does not map. Writes to them must
    // leave both thresholds untouched.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = CFG_IDX_W'(3);

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 pin_level;
    logic                 out_valid;
    logic                 out_ready;
    logic                 long_push_flag;
    logic                 double_click_flag;
    logic                 restart_request;
    logic [1:0]           button_phase;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    button_click_long_press_detector_core u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .pin_level         (pin_level),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .long_push_flag    (long_push_flag),
        .double_click_flag (double_click_flag),
        .restart_request   (restart_request),
        .button_phase      (button_phase),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // The detector as the bench sees it: its own copy of the registers and
    // of every piece of state, advanced once per accepted input beat.
    logic [WINDOW_W-1:0] click_window;
    logic [HOLD_W-1:0]   long_limit;
    phase_t              model_phase;
    logic [HOLD_W-1:0]   held_ticks;
    logic [WINDOW_W-1:0] window_age;
    logic                pending_click;
    logic                window_open;
    logic                long_seen;
    logic                double_seen;

    // Output beats predicted but not yet seen, oldest first.
    bclp_result_t predicted_outputs[$];

    int mismatch_count;
    int sent_items;
    int send_idle_pct;
    int recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    task clear_predictor();
        begin
            click_window  = WINDOW_RESET;
            long_limit    = LONG_PUSH_RESET;
            model_phase   = PH_IDLE;
            held_ticks    = '0;
            window_age    = '0;
            pending_click = 1'b0;
            window_open   = 1'b0;
            long_seen     = 1'b0;
            double_seen   = 1'b0;
        end
    endtask

    // One tick of the detector. The open click window is aged first, so a
    // window whose age has already passed the limit is gone before the phase
    // logic looks at the pending click.
    task predict_tick(input logic pin, output bclp_result_t res);
        logic                pressed;
        logic                restart;
        logic [WINDOW_W-1:0] prev_age;
        begin
            pressed = ~pin;
            restart = 1'b0;

            if (window_open)
            begin
                prev_age   = window_age;
                window_age = window_age + WINDOW_W'(1);
                if (prev_age > click_window)
                begin
                    pending_click = 1'b0;
                    window_age    = '0;
                    window_open   = 1'b0;
                end
            end

            case (model_phase)
                PH_IDLE:
                begin
                    long_seen   = 1'b0;
                    double_seen = 1'b0;
                    if (pressed)
                    begin
                        model_phase = PH_PRESS;
                        held_ticks  = '0;
                    end
                end
                PH_PRESS:
                begin
                    // The hold counter sticks at its top value, so a threshold
                    // at the top can never be passed.
                    if (held_ticks != HOLD_MAX)
                        held_ticks = held_ticks + HOLD_W'(1);
                    if (!pressed)
                    begin
                        window_open = 1'b1;
                        if (pending_click)
                        begin
                            pending_click = 1'b0;
                            window_open   = 1'b0;
                            window_age    = '0;
                            model_phase   = PH_DOUBLE;
                        end
                        else
                        begin
                            pending_click = 1'b1;
                            model_phase   = PH_IDLE;
                        end
                    end
                    else if (held_ticks > long_limit)
                    begin
                        model_phase = PH_LONG;
                        restart     = 1'b1;
                    end
                end
                PH_LONG:
                begin
                    long_seen = 1'b1;
                    if (!pressed)
                        model_phase = PH_IDLE;
                end
                default:
                begin
                    double_seen = 1'b1;
                    if (!pressed)
                        model_phase = PH_IDLE;
                end
            endcase

            res.long_push_flag    = long_seen;
            res.double_click_flag = double_seen;
            res.restart_request   = restart;
            res.button_phase      = model_phase;
        end
    endtask

    // Sends one pin sample. The sender may idle for a random number of cycles
    // first; valid is only lowered in cycles where no new beat is offered, so
    // back-to-back beats keep valid high without a glitch.
    task send_sample(input logic pin);
        bclp_result_t res;
        begin
            @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid  <= 1'b1;
            pin_level <= pin;
            do
                @(posedge clk);
            while (!in_ready);
            predict_tick(pin, res);
            predicted_outputs.push_back(res);
            sent_items++;
        end
    endtask

    task hold_level(input logic pin, input int ticks);
        begin
            repeat (ticks) send_sample(pin);
        end
    endtask

    // Stops offering input and waits for every predicted beat to come back.
    // Every beat produces exactly one result, so once the store is empty the
    // block is idle apart from its registered output stage.
    task drain_results();
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (predicted_outputs.size() != 0)
                @(posedge clk);
            repeat (2) @(posedge clk);
        end
    endtask

    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            do
                @(posedge clk);
            while (!cfg_ready);
            // Only the low byte of the data reaches the window register.
            if (idx == REG_DOUBLE_CLICK_WINDOW)
                click_window = val[WINDOW_W-1:0];
            else if (idx == REG_LONG_PUSH_TICKS)
                long_limit = val;
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    // Receiver: ready is redrawn every cycle from the current idle share.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task compare_field(input string name, input logic [1:0] exp, input logic [1:0] act);
        begin
            if (act !== exp)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
                mismatch_count++;
            end
        end
    endtask

    // Every accepted output beat is matched against the oldest prediction.
    initial
    begin
        bclp_result_t exp;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (predicted_outputs.size() == 0)
                begin
                    $display("%0t: unexpected output beat, expected none, actual phase %0d",
                             $time, button_phase);
                    mismatch_count++;
                end
                else
                begin
                    exp = predicted_outputs.pop_front();
                    compare_field("long_push_flag", {1'b0, exp.long_push_flag},
                                  {1'b0, long_push_flag});
                    compare_field("double_click_flag", {1'b0, exp.double_click_flag},
                                  {1'b0, double_click_flag});
                    compare_field("restart_request", {1'b0, exp.restart_request},
                                  {1'b0, restart_request});
                    compare_field("button_phase", exp.button_phase, button_phase);
                end
            end
        end
    end

    // Default thresholds: two quick clicks make a double click, the flag comes
    // up one tick after the phase is entered and clears once idle runs again.
    task test_double_click();
        begin
            send_sample(1'b1);
            send_sample(1'b0);
            send_sample(1'b1);
            send_sample(1'b0);
            send_sample(1'b1);
            send_sample(1'b0);
            send_sample(1'b1);
            send_sample(1'b1);
        end
    endtask

    // Both thresholds at zero: a two-tick hold is already a long push, and a
    // click window dies one tick after its age passes zero.
    task test_long_push_and_expiry();
        begin
            drain_results();
            write_reg(REG_DOUBLE_CLICK_WINDOW, 16'hFF00);
            write_reg(REG_LONG_PUSH_TICKS, 16'h0000);
            write_reg(REG_UNMAPPED_LO, 16'hFFFF);
            write_reg(REG_UNMAPPED_HI, 16'h5A5A);

            // Press, pass the threshold, see the flag, release, clear.
            hold_level(1'b0, 3);
            hold_level(1'b1, 2);

            // A single click, then enough released ticks for the window to
            // expire, so the next click starts over instead of pairing up.
            send_sample(1'b0);
            hold_level(1'b1, 4);
            send_sample(1'b0);
            hold_level(1'b1, 2);
        end
    endtask

    // Well-formed clicks and holds with random timing, salted with noise. Each
    // call walks through four threshold settings, low ones and near-top ones.
    task test_random_gestures(input int n_items);
        int seg;
        int seg_end;
        int kind;
        int gap;
        int gap_cap;
        begin
            for (seg = 0; seg < 4; seg++)
            begin
                drain_results();
                case (seg)
                    0:
                    begin
                        write_reg(REG_DOUBLE_CLICK_WINDOW, {8'($urandom), 8'd0});
                        write_reg(REG_LONG_PUSH_TICKS, 16'($urandom_range(0, 3)));
                    end
                    1:
                    begin
                        write_reg(REG_DOUBLE_CLICK_WINDOW, {8'($urandom), 8'd254});
                        write_reg(REG_LONG_PUSH_TICKS, 16'd65534);
                    end
                    2:
                    begin
                        write_reg(REG_DOUBLE_CLICK_WINDOW,
                                  {8'($urandom), 8'($urandom_range(1, 12))});
                        write_reg(REG_LONG_PUSH_TICKS, 16'($urandom_range(4, 40)));
                    end
                    default:
                    begin
                        write_reg(REG_DOUBLE_CLICK_WINDOW, 16'($urandom_range(0, 254)));
                        write_reg(REG_LONG_PUSH_TICKS, 16'($urandom_range(0, 20)));
                    end
                endcase

                seg_end = sent_items + n_items / 4;
                while (sent_items < seg_end)
                begin
                    kind = $urandom_range(0, 9);
                    if (kind == 0)
                    begin
                        repeat ($urandom_range(1, 8)) send_sample(1'($urandom_range(0, 1)));
                    end
                    else if (kind <= 2 && long_limit < 200)
                    begin
                        hold_level(1'b0, int'(long_limit) + $urandom_range(1, 6));
                        hold_level(1'b1, $urandom_range(1, 4));
                    end
                    else
                    begin
                        // Mostly short gaps so that second clicks land inside
                        // the window; now and then a gap that lets it expire.
                        hold_level(1'b0, $urandom_range(1, 4));
                        gap_cap = (click_window < 8) ? int'(click_window) : 8;
                        if ($urandom_range(0, 9) < 7)
                            gap = $urandom_range(0, gap_cap);
                        else
                            gap = $urandom_range(0, int'(click_window) + 3);
                        hold_level(1'b1, 1 + gap);
                    end
                end
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        pin_level      = 1'b1;
        cfg_valid      = 1'b0;
        cfg_index      = REG_DOUBLE_CLICK_WINDOW;
        cfg_data       = '0;
        mismatch_count = 0;
        sent_items     = 0;
        send_idle_pct  = 22;
        recv_idle_pct  = 88;
        clear_predictor();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Slow receiver first, then slow sender, then full rate.
        test_double_click();
        test_long_push_and_expiry();
        test_random_gestures(400);

        send_idle_pct = 88;
        recv_idle_pct = 22;
        test_random_gestures(400);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_gestures(400);

        drain_results();
        repeat (4) @(posedge clk);

        if (mismatch_count == 0)
            $display("[button_click_long_press_detector_core] OK");
        else
            $display("[button_click_long_press_detector_core] ERROR");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("[button_click_long_press_detector_core] ERROR");
        $finish;
    end

endmodule
